FILE: design/zoned_bitmap_page_allocator_unit_assert.svh
// assertion macros shared by the allocator rtl
`ifndef ZONED_BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define ZONED_BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// clocked assertion, muted while reset is asserted
`define ZBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication built on the macro above
`define ZBPA_ASSERT_IMP(lbl, pre, post, msg) \
  `ZBPA_ASSERT(lbl, (pre) |-> (post), msg)

`endif

FILE: design/zbpa_pkg.sv
package zbpa_pkg;

  localparam int MaxPages = 65536;
  localparam int WordBits = 64;
  localparam int Words    = MaxPages / WordBits;
  localparam int WordAw   = $clog2(Words);
  localparam int BitAw    = $clog2(WordBits);
  localparam int PageW    = 16;
  localparam int CntW     = 17;

  localparam logic [1:0] ReqOne  = 2'd0;
  localparam logic [1:0] ReqRun  = 2'd1;
  localparam logic [1:0] ReqFree = 2'd2;
  localparam logic [1:0] ReqRsv  = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoSpace = 3'd1;
  localparam logic [2:0] StRange   = 3'd2;
  localparam logic [2:0] StRsvPage = 3'd3;
  localparam logic [2:0] StDouble  = 3'd4;

  localparam logic CfgTotal = 1'b0;
  localparam logic CfgDma   = 1'b1;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [PageW-1:0] page_number;
    logic [CntW-1:0]  page_count;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [PageW-1:0] result_page;
    logic [CntW-1:0]  free_count;
  } rsp_t;

endpackage

FILE: design/zoned_bitmap_page_allocator_unit.sv
// Page-frame allocator over a 64K-page map held as two 1024 x 64 bit memories (used bits
// and reserved bits), read one word per cycle with a registered read port. Requests are
// taken one at a time; each gives exactly one result transaction with status, page and
// the free count. The single map port sets the cost: single-page allocation scans map
// words zone phase by zone phase over both zones; a contiguous run takes each all-free or
// all-used word whole and each mixed word eight pages at a time, then marks the run word
// by word; free touches one word; reserve reads, writes and counts each word of the range.
// After reset a clearing pass zeroes the maps, during which no request is accepted;
// configuration writes are taken at any time but belong in idle periods. A write of the
// page-total register reloads the free count; the dma-zone register sets where the normal
// zone starts.
module zoned_bitmap_page_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  zbpa_pkg::req_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output zbpa_pkg::rsp_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [zbpa_pkg::CntW-1:0] cfg_wdata_i
);
  import zbpa_pkg::*;
  `include "zoned_bitmap_page_allocator_unit_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PHASE, S_LOAD, S_EVAL, S_RSUB, S_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_ONE, OP_RUN, OP_MARK, OP_RSV, OP_FREE
  } op_e;

  localparam logic [CntW-1:0]   CntMax  = '1;
  localparam logic [CntW-1:0]   MaxP    = CntW'(MaxPages);
  localparam logic [WordAw-1:0] LastWrd = WordAw'(Words - 1);

  // map memories
  logic [WordBits-1:0] used_mem [Words];
  logic [WordBits-1:0] rsv_mem  [Words];
  logic [WordBits-1:0] rd_used_q, rd_rsv_q;
  logic                mem_we;
  logic [WordBits-1:0] wr_used, wr_rsv;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [WordAw-1:0]   w_q, w_d;
  logic [CntW-1:0]     s_q, s_d, e_q, e_d;
  logic [2:0]          phase_q, phase_d;
  logic [CntW-1:0]     run_q, run_d;
  logic [PageW-1:0]    first_q, first_d;
  logic [2:0]          chunk_q, chunk_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PageW-1:0]    pn_q, pn_d;
  logic [BitAw:0]      pop_q, pop_d;
  logic [2:0]          st_q, st_d;
  logic [PageW-1:0]    page_q, page_d;
  logic [CntW-1:0]     free_q, free_d;
  logic [PageW-1:0]    nh_q, nh_d, dh_q, dh_d;
  logic [CntW-1:0]     total_q, total_d, dma_q, dma_d;
  rsp_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [CntW-1:0]     t_eff, d_eff, size1, e_m1, cfg_t_eff;
  logic [PageW-1:0]    h1, h2;
  logic [WordAw-1:0]   last_w;
  logic [WordBits-1:0] lo_mask, hi_mask, rng, free_bits, lowest;
  logic [BitAw-1:0]    ffs_idx;

  function automatic logic [BitAw:0] popcount(input logic [WordBits-1:0] v);
    logic [BitAw:0] sum;
    logic [3:0]     part;
    sum = '0;
    for (int b = 0; b < WordBits / 8; b++) begin
      part = '0;
      for (int j = 0; j < 8; j++) part = part + 4'(v[b*8+j]);
      sum = sum + (BitAw+1)'(part);
    end
    return sum;
  endfunction

  function automatic logic [CntW-1:0] sat_sub(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] n);
    return (a > n) ? a - n : '0;
  endfunction

  // effective zone limits
  assign t_eff     = (total_q > MaxP) ? MaxP : total_q;
  assign d_eff     = (dma_q < t_eff) ? dma_q : t_eff;
  assign cfg_t_eff = (cfg_wdata_i > MaxP) ? MaxP : cfg_wdata_i;
  assign size1     = t_eff - d_eff;
  // a stale hint falls back to the zone start
  assign h1        = ({1'b0, nh_q} < size1) ? nh_q : '0;
  assign h2        = ({1'b0, dh_q} < d_eff) ? dh_q : '0;

  // in-range bits of the current word for the window [s, e)
  assign e_m1      = e_q - 1'b1;
  assign last_w    = e_m1[PageW-1:BitAw];
  assign lo_mask   = (w_q == s_q[PageW-1:BitAw]) ? ('1 << s_q[BitAw-1:0]) : '1;
  assign hi_mask   = (w_q == last_w) ? ('1 >> (BitAw'(WordBits - 1) - e_m1[BitAw-1:0])) : '1;
  assign rng       = lo_mask & hi_mask;
  assign free_bits = ~rd_used_q & rng;

  // lowest free bit of the word
  assign lowest = free_bits & (~free_bits + 1'b1);
  always_comb begin
    ffs_idx = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (lowest[i]) ffs_idx = ffs_idx | BitAw'(i);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [CntW-1:0]  cs, ce, endp, base, zsize, rel1;
    logic [PageW-1:0] pg, fst;
    logic [CntW-1:0]  r;
    logic [CntW:0]    sum;
    logic [7:0]       byte_bits;
    logic             hit, found, advance;

    state_d = state_q;  op_d = op_q;  w_d = w_q;  s_d = s_q;  e_d = e_q;
    phase_d = phase_q;  run_d = run_q;  first_d = first_q;  chunk_d = chunk_q;
    cnt_d = cnt_q;  pn_d = pn_q;  pop_d = pop_q;  st_d = st_q;  page_d = page_q;
    free_d = free_q;  nh_d = nh_q;  dh_d = dh_q;  total_d = total_q;  dma_d = dma_q;
    out_d = out_q;  out_valid_d = out_valid_q;
    mem_we = 1'b0;  wr_used = rd_used_q;  wr_rsv = rd_rsv_q;
    cs = '0;  ce = '0;  endp = '0;  base = '0;  zsize = '0;  rel1 = '0;
    pg = '0;  fst = first_q;  r = run_q;  sum = '0;  byte_bits = '0;
    hit = 1'b0;  found = 1'b0;  advance = 1'b0;

    // a taken result frees the output register
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_used = '0;
        wr_rsv  = '0;
        if (w_q == LastWrd) begin
          w_d     = '0;
          state_d = S_IDLE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d  = in_data_i.page_count;
          pn_d   = in_data_i.page_number;
          st_d   = StOk;
          page_d = '0;
          unique case (in_data_i.req_type)
            ReqOne: begin
              op_d    = OP_ONE;
              phase_d = '0;
              state_d = S_PHASE;
            end
            ReqRun: begin
              if (in_data_i.page_count == CntW'(1)) begin
                // a run of one page is a plain single-page allocation
                op_d    = OP_ONE;
                phase_d = '0;
                state_d = S_PHASE;
              end else if (in_data_i.page_count == '0 || d_eff >= t_eff) begin
                st_d    = StNoSpace;
                state_d = S_FIN;
              end else begin
                op_d    = OP_RUN;
                s_d     = d_eff;
                e_d     = t_eff;
                w_d     = d_eff[PageW-1:BitAw];
                run_d   = '0;
                chunk_d = '0;
                state_d = S_LOAD;
              end
            end
            ReqFree: begin
              if ({1'b0, in_data_i.page_number} >= t_eff) begin
                st_d    = StRange;
                state_d = S_FIN;
              end else begin
                op_d    = OP_FREE;
                w_d     = in_data_i.page_number[PageW-1:BitAw];
                state_d = S_LOAD;
              end
            end
            ReqRsv: begin
              // range is clipped at the managed total
              endp = {1'b0, in_data_i.page_number} + in_data_i.page_count;
              ce   = (endp < t_eff) ? endp : t_eff;
              if ({1'b0, in_data_i.page_number} >= ce) begin
                state_d = S_FIN;
              end else begin
                op_d    = OP_RSV;
                s_d     = {1'b0, in_data_i.page_number};
                e_d     = ce;
                w_d     = in_data_i.page_number[PageW-1:BitAw];
                state_d = S_LOAD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_PHASE: begin
        // normal zone from hint, normal zone below hint, then the same for dma
        case (phase_q)
          3'd0: begin cs = d_eff + {1'b0, h1}; ce = t_eff; end
          3'd1: begin cs = d_eff; ce = d_eff + {1'b0, h1}; end
          3'd2: begin cs = {1'b0, h2}; ce = d_eff; end
          3'd3: begin cs = '0; ce = {1'b0, h2}; end
          default: begin cs = '0; ce = '0; end
        endcase
        if (phase_q > 3'd3) begin
          st_d    = StNoSpace;
          state_d = S_FIN;
        end else if (cs < ce) begin
          s_d     = cs;
          e_d     = ce;
          w_d     = cs[PageW-1:BitAw];
          state_d = S_LOAD;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end

      S_LOAD: state_d = S_EVAL;

      S_EVAL: begin
        unique case (op_q)
          OP_ONE: begin
            if (|free_bits) begin
              pg      = {w_q, ffs_idx};
              mem_we  = 1'b1;
              wr_used = rd_used_q | lowest;
              free_d  = sat_sub(free_q, CntW'(1));
              page_d  = pg;
              base    = (phase_q < 3'd2) ? d_eff : '0;
              zsize   = (phase_q < 3'd2) ? size1 : d_eff;
              rel1    = {1'b0, pg} - base + 1'b1;
              if (phase_q < 3'd2) nh_d = (rel1 == zsize) ? '0 : rel1[PageW-1:0];
              else                dh_d = (rel1 == zsize) ? '0 : rel1[PageW-1:0];
              state_d = S_FIN;
            end else if (w_q == last_w) begin
              phase_d = phase_q + 1'b1;
              state_d = S_PHASE;
            end else begin
              w_d     = w_q + 1'b1;
              state_d = S_LOAD;
            end
          end

          OP_RUN: begin
            if (chunk_q == '0 && free_bits == '1) begin
              // whole word free: extend the run by a full word
              fst = (run_q == '0) ? {w_q, {BitAw{1'b0}}} : first_q;
              sum = {1'b0, run_q} + (CntW+1)'(WordBits);
              if (sum >= {1'b0, cnt_q}) begin
                found = 1'b1;
              end else begin
                run_d   = sum[CntW-1:0];
                first_d = fst;
                advance = 1'b1;
              end
            end else if (chunk_q == '0 && free_bits == '0) begin
              run_d   = '0;
              advance = 1'b1;
            end else begin
              // mixed word: eight pages a cycle
              byte_bits = free_bits[{chunk_q, 3'b000} +: 8];
              for (int j = 0; j < 8; j++) begin
                if (!hit) begin
                  if (byte_bits[j]) begin
                    if (r == '0) fst = {w_q, chunk_q, 3'(j)};
                    r = r + 1'b1;
                    if (r == cnt_q) hit = 1'b1;
                  end else begin
                    r = '0;
                  end
                end
              end
              if (hit) begin
                found = 1'b1;
              end else begin
                run_d   = r;
                first_d = fst;
                if (chunk_q == 3'd7) begin
                  chunk_d = '0;
                  advance = 1'b1;
                end else begin
                  chunk_d = chunk_q + 1'b1;
                end
              end
            end
            if (found) begin
              // switch to marking the run as used
              op_d    = OP_MARK;
              first_d = fst;
              page_d  = fst;
              s_d     = {1'b0, fst};
              e_d     = {1'b0, fst} + cnt_q;
              w_d     = fst[PageW-1:BitAw];
              chunk_d = '0;
              free_d  = sat_sub(free_q, cnt_q);
              state_d = S_LOAD;
            end else if (advance) begin
              if (w_q == last_w) begin
                st_d    = StNoSpace;
                state_d = S_FIN;
              end else begin
                w_d     = w_q + 1'b1;
                state_d = S_LOAD;
              end
            end
          end

          OP_MARK: begin
            mem_we  = 1'b1;
            wr_used = rd_used_q | rng;
            if (w_q == last_w) begin
              state_d = S_FIN;
            end else begin
              w_d     = w_q + 1'b1;
              state_d = S_LOAD;
            end
          end

          OP_RSV: begin
            // already reserved pages are skipped
            mem_we  = 1'b1;
            wr_rsv  = rd_rsv_q | rng;
            wr_used = rd_used_q | (rng & ~rd_rsv_q);
            pop_d   = popcount(rng & ~rd_rsv_q & ~rd_used_q);
            state_d = S_RSUB;
          end

          OP_FREE: begin
            if (rd_rsv_q[pn_q[BitAw-1:0]]) begin
              st_d = StRsvPage;
            end else if (!rd_used_q[pn_q[BitAw-1:0]]) begin
              st_d = StDouble;
            end else begin
              mem_we  = 1'b1;
              wr_used = rd_used_q & ~({{(WordBits-1){1'b0}}, 1'b1} << pn_q[BitAw-1:0]);
              free_d  = (free_q < CntMax) ? free_q + 1'b1 : free_q;
            end
            state_d = S_FIN;
          end

          default: state_d = S_FIN;
        endcase
      end

      S_RSUB: begin
        free_d = sat_sub(free_q, CntW'(pop_q));
        if (w_q == last_w) begin
          state_d = S_FIN;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = S_LOAD;
        end
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = st_q;
          out_d.result_page = page_q;
          out_d.free_count  = free_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTotal: begin
          total_d = cfg_wdata_i;
          free_d  = cfg_t_eff;
        end
        CfgDma:   dma_d = cfg_wdata_i;
        default:  dma_d = dma_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_ONE;
      w_q         <= '0;
      phase_q     <= '0;
      run_q       <= '0;
      chunk_q     <= '0;
      nh_q        <= '0;
      dh_q        <= '0;
      free_q      <= MaxP;
      total_q     <= MaxP;
      dma_q       <= CntW'(4096);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      w_q         <= w_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      chunk_q     <= chunk_d;
      nh_q        <= nh_d;
      dh_q        <= dh_d;
      free_q      <= free_d;
      total_q     <= total_d;
      dma_q       <= dma_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    e_q     <= e_d;
    first_q <= first_d;
    cnt_q   <= cnt_d;
    pn_q    <= pn_d;
    pop_q   <= pop_d;
    st_q    <= st_d;
    page_q  <= page_d;
    out_q   <= out_d;
  end

  // map memories, one read and one write port on the same word address
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      used_mem[w_q] <= wr_used;
      rsv_mem[w_q]  <= wr_rsv;
    end
    rd_used_q <= used_mem[w_q];
    rd_rsv_q  <= rsv_mem[w_q];
  end

  `ZBPA_ASSERT_IMP(a_write_states, mem_we,
                   (state_q == S_EVAL || state_q == S_CLEAR), "map written outside eval or clear")
  `ZBPA_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN),
               "result raised without finishing a request")
  `ZBPA_ASSERT_IMP(a_scan_in_window, (state_q == S_EVAL && op_q != OP_FREE),
                   (w_q <= last_w), "scan word beyond window end")
  `ZBPA_ASSERT(a_accept_leaves_idle, (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE),
               "accepted request did not start")

endmodule

FILE: tb/zoned_bitmap_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module zoned_bitmap_page_allocator_unit_tb;
  import zbpa_pkg::*;

  localparam int PageLimit = 65536;
  localparam int CountMax  = 131071;
  localparam int CycleLimit = 20000000;

  // page map model with its own zone hints and free counter
  class page_map_scoreboard;
    bit   used_m[PageLimit];
    bit   rsv_m[PageLimit];
    int   normal_hint;
    int   dma_hint;
    int   free_left;
    int   total_reg;
    int   dma_reg;
    rsp_t pending_q[$];
    int   mismatches;

    function new();
      normal_hint = 0;
      dma_hint    = 0;
      free_left   = 65536;
      total_reg   = 65536;
      dma_reg     = 4096;
      mismatches  = 0;
    endfunction

    function void write_reg(logic idx, int val);
      if (idx == CfgTotal) begin
        total_reg = val;
        free_left = (val < PageLimit) ? val : PageLimit;
      end else begin
        dma_reg = val;
      end
    endfunction

    function int zone_total();
      return (total_reg < PageLimit) ? total_reg : PageLimit;
    endfunction

    function void take_pages(int n);
      free_left = (free_left > n) ? free_left - n : 0;
    endfunction

    // next-fit search within one zone, hint wraps around the zone
    function bit zone_grab(int base, int size, ref int hint, output int page);
      int h;
      int i;
      page = 0;
      if (size == 0) return 0;
      h = (hint < size) ? hint : 0;
      for (int k = 0; k < size; k++) begin
        i = h + k;
        if (i >= size) i -= size;
        if (!used_m[base + i]) begin
          hint = (i + 1) % size;
          used_m[base + i] = 1;
          take_pages(1);
          page = base + i;
          return 1;
        end
      end
      return 0;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t e;
      int   t;
      int   d;
      int   cnt;
      int   pn;
      int   page;
      int   run;
      int   first;
      bit   ok;
      t   = zone_total();
      d   = (dma_reg < t) ? dma_reg : t;
      cnt = r.page_count;
      pn  = r.page_number;
      e.status = StOk;
      page = 0;
      if (r.req_type == ReqOne || (r.req_type == ReqRun && cnt == 1)) begin
        ok = zone_grab(d, t - d, normal_hint, page);
        if (!ok) ok = zone_grab(0, d, dma_hint, page);
        if (!ok) begin
          e.status = StNoSpace;
          page = 0;
        end
      end else if (r.req_type == ReqRun) begin
        // first fit from the start of the normal zone
        ok = 0;
        run = 0;
        first = 0;
        if (cnt != 0) begin
          for (int i = d; i < t && !ok; i++) begin
            if (!used_m[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == cnt) ok = 1;
            end else begin
              run = 0;
            end
          end
        end
        if (ok) begin
          for (int k = 0; k < cnt; k++) used_m[first + k] = 1;
          take_pages(cnt);
          page = first;
        end else begin
          e.status = StNoSpace;
        end
      end else if (r.req_type == ReqFree) begin
        if (pn >= t) e.status = StRange;
        else if (rsv_m[pn]) e.status = StRsvPage;
        else if (!used_m[pn]) e.status = StDouble;
        else begin
          used_m[pn] = 0;
          if (free_left < CountMax) free_left++;
        end
      end else begin
        // reserve walk stops at the zone total, already reserved pages skipped
        for (int p = pn; p < pn + cnt && p < t; p++) begin
          if (!rsv_m[p]) begin
            rsv_m[p] = 1;
            if (!used_m[p]) begin
              used_m[p] = 1;
              take_pages(1);
            end
          end
        end
      end
      e.result_page = page[PageW-1:0];
      e.free_count  = free_left[CntW-1:0];
      pending_q.push_back(e);
      return e;
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: status %0d page %0d free %0d",
                   a.status, a.result_page, a.free_count);
        return;
      end
      e = pending_q.pop_front();
      if (a.status !== e.status || a.result_page !== e.result_page ||
          a.free_count !== e.free_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d page %0d free %0d, got %0d %0d %0d",
                   e.status, e.result_page, e.free_count,
                   a.status, a.result_page, a.free_count);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CntW-1:0] cfg_wdata_i;

  page_map_scoreboard sb;
  int idle_mode;   // 0 none, 1 sender 62%, 2 receiver 62%, 3 both 8%
  int hold_left;   // long receiver hold-off, counted down by the receiver
  int cycles;
  int owned_q[$];  // pages known to be allocated, used to build legal frees

  zoned_bitmap_page_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_data_o);
  end

  // receiver stall pattern, one assignment per falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (idle_mode == 2) begin
        out_stall_i <= ($urandom_range(0, 99) < 62);
      end else if (idle_mode == 3) begin
        out_stall_i <= ($urandom_range(0, 99) < 8);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // valid is left high after acceptance; it only drops on an idle cycle
  task automatic send_request(req_t r);
    rsp_t e;
    int   pct;
    pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 8 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    e = sb.note_request(r);
    if (e.status == StOk && r.req_type == ReqOne) owned_q.push_back(e.result_page);
    if (e.status == StOk && r.req_type == ReqRun)
      for (int k = 0; k < r.page_count; k++) owned_q.push_back(e.result_page + k);
    @(negedge clk_i);
  endtask

  task automatic issue(logic [1:0] kind, int pn, int cnt);
    req_t r;
    r.req_type    = kind;
    r.page_number = pn[PageW-1:0];
    r.page_count  = cnt[CntW-1:0];
    send_request(r);
  endtask

  // sender pauses until every expected transaction has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CntW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic random_request();
    int t;
    int roll;
    int cnt;
    int pn;
    int j;
    t = sb.zone_total();
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      issue(ReqOne, $urandom_range(0, 65535), $urandom_range(0, 131071));
    end else if (roll < 50) begin
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65536) : $urandom_range(0, 12);
      issue(ReqRun, $urandom_range(0, 65535), cnt);
    end else if (roll < 92) begin
      // mostly frees of pages in use, plus stray and out-of-range pages
      if (owned_q.size() != 0 && $urandom_range(0, 99) < 70) begin
        j  = $urandom_range(0, owned_q.size() - 1);
        pn = owned_q[j];
        owned_q.delete(j);
      end else if ($urandom_range(0, 1) == 0) begin
        pn = $urandom_range(0, 65535);
      end else begin
        pn = $urandom_range(0, (t + 8 < 65535) ? t + 8 : 65535);
      end
      issue(ReqFree, pn, $urandom_range(0, 131071));
    end else begin
      pn  = $urandom_range(0, (t + 8 < 65535) ? t + 8 : 65535);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) pn = $urandom_range(0, 65535);
      issue(ReqRsv, pn, cnt);
    end
  endtask

  initial begin
    int totals[6];
    int dmas[6];
    sb          = new();
    idle_mode   = 0;
    hold_left   = 0;
    cycles      = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgTotal;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, every request kind and corner
    issue(ReqOne, 0, 0);
    issue(ReqRun, 65535, 0);
    issue(ReqRun, 0, 1);
    issue(ReqRun, 0, 3);
    issue(ReqFree, 4096, 0);
    issue(ReqFree, 4096, 0);
    issue(ReqFree, 0, 0);
    issue(ReqRsv, 10, 5);
    issue(ReqFree, 12, 0);
    issue(ReqRsv, 8, 4);
    issue(ReqRsv, 65535, 65536);
    issue(ReqFree, 65535, 131071);
    issue(ReqRsv, 65534, 0);
    issue(ReqRun, 0, 65536);
    issue(ReqOne, 0, 0);
    drain();

    // empty page map: allocations fail, the free is out of range, the reserve covers no page
    write_reg(CfgTotal, 0);
    write_reg(CfgDma, 0);
    issue(ReqOne, 0, 0);
    issue(ReqRun, 0, 2);
    issue(ReqFree, 0, 0);
    issue(ReqRsv, 0, 65536);
    drain();

    // tiny zones, exhaust the normal zone and spill into the dma zone
    write_reg(CfgTotal, 6);
    write_reg(CfgDma, 2);
    repeat (7) issue(ReqOne, 0, 0);
    issue(ReqFree, 1, 0);
    issue(ReqFree, 6, 0);
    drain();

    totals = '{256, 1024, 128, 300, 2048, 65536};
    dmas   = '{64, 0, 128, 65536, 512, 65536};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgTotal, totals[ph]);
      write_reg(CfgDma, dmas[ph]);
      owned_q.delete();
      for (int n = 0; n < 84; n++) begin
        idle_mode = (n / 21 + ph) % 4;
        if (ph == 1 && n == 10) hold_left = 400;
        if (ph == 2 && n == 40) drain();
        random_request();
      end
      drain();
    end

    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
